@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion helpers, clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define TRK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be true at a clock edge outside reset.
`define TRK_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

@@ rtl/aabb_tot_pkg.sv @@
// ----------------------------------------------------------------------------
// aabb_tot_pkg
// Types, constants and pair tables shared by the overlap tracker.
// ----------------------------------------------------------------------------
package aabb_tot_pkg;

  localparam int MAX_TRIGGERS = 8;
  localparam int COORD_BITS   = 24;
  localparam int OWNER_BITS   = 8;
  localparam int SLOT_W       = 3;
  localparam int IDX_W        = $clog2(MAX_TRIGGERS);
  localparam int PAIR_COUNT   = (MAX_TRIGGERS * (MAX_TRIGGERS - 1)) / 2;
  localparam int PAIR_W       = $clog2(PAIR_COUNT);
  localparam int EV_COUNT     = 2 * PAIR_COUNT;
  localparam int EV_W         = $clog2(EV_COUNT);
  localparam int IN_DATA_W    = 160;
  localparam int OUT_DATA_W   = 8;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_REMOVE = 2'd1,
    OP_TICK   = 2'd2
  } op_e;

  localparam logic KIND_ENTER = 1'b0;
  localparam logic KIND_EXIT  = 1'b1;

  // One stored box; owner in the lowest bits.
  typedef struct packed {
    logic signed [COORD_BITS-1:0] hi_z;
    logic signed [COORD_BITS-1:0] hi_y;
    logic signed [COORD_BITS-1:0] hi_x;
    logic signed [COORD_BITS-1:0] lo_z;
    logic signed [COORD_BITS-1:0] lo_y;
    logic signed [COORD_BITS-1:0] lo_x;
    logic [OWNER_BITS-1:0]        owner;
  } box_t;

  localparam int BOX_W = $bits(box_t);

  typedef logic [PAIR_COUNT-1:0][SLOT_W-1:0] pair_tab_t;

  // Lower slot of each pair in ascending pair order.
  function automatic pair_tab_t build_first();
    pair_tab_t t;
    int p;
    t = '0;
    p = 0;
    for (int i = 0; i < MAX_TRIGGERS; i++) begin
      for (int j = i + 1; j < MAX_TRIGGERS; j++) begin
        t[p] = SLOT_W'(i);
        p++;
      end
    end
    return t;
  endfunction

  // Higher slot of each pair in ascending pair order.
  function automatic pair_tab_t build_second();
    pair_tab_t t;
    int p;
    t = '0;
    p = 0;
    for (int i = 0; i < MAX_TRIGGERS; i++) begin
      for (int j = i + 1; j < MAX_TRIGGERS; j++) begin
        t[p] = SLOT_W'(j);
        p++;
      end
    end
    return t;
  endfunction

  localparam pair_tab_t PAIR_FIRST  = build_first();
  localparam pair_tab_t PAIR_SECOND = build_second();

  // Pairs that involve the given slot.
  function automatic logic [PAIR_COUNT-1:0] slot_pairs(logic [IDX_W-1:0] s);
    logic [PAIR_COUNT-1:0] m;
    int p;
    m = '0;
    p = 0;
    for (int i = 0; i < MAX_TRIGGERS; i++) begin
      for (int j = i + 1; j < MAX_TRIGGERS; j++) begin
        m[p] = (s == IDX_W'(i)) || (s == IDX_W'(j));
        p++;
      end
    end
    return m;
  endfunction

  // Pairs whose two slots are both valid.
  function automatic logic [PAIR_COUNT-1:0] valid_pairs(logic [MAX_TRIGGERS-1:0] v);
    logic [PAIR_COUNT-1:0] m;
    int p;
    m = '0;
    p = 0;
    for (int i = 0; i < MAX_TRIGGERS; i++) begin
      for (int j = i + 1; j < MAX_TRIGGERS; j++) begin
        m[p] = v[i] & v[j];
        p++;
      end
    end
    return m;
  endfunction

endpackage

@@ rtl/aabb_tot_ram.sv @@
// ----------------------------------------------------------------------------
// aabb_tot_ram
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module aabb_tot_ram #(
  parameter int Width = 8,
  parameter int Depth = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered reads.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

@@ rtl/aabb_tot_hit.sv @@
// ----------------------------------------------------------------------------
// aabb_tot_hit
// Inclusive axis-aligned box test on three axes, signed coordinates.
// ----------------------------------------------------------------------------
module aabb_tot_hit
  import aabb_tot_pkg::*;
(
  input  box_t box_a_i,
  input  box_t box_b_i,
  output logic hit_o
);

  logic hit_x, hit_y, hit_z;

  // Each axis overlaps when the intervals touch or cross.
  assign hit_x = (box_a_i.lo_x <= box_b_i.hi_x) && (box_a_i.hi_x >= box_b_i.lo_x);
  assign hit_y = (box_a_i.lo_y <= box_b_i.hi_y) && (box_a_i.hi_y >= box_b_i.lo_y);
  assign hit_z = (box_a_i.lo_z <= box_b_i.hi_z) && (box_a_i.hi_z >= box_b_i.lo_z);

  assign hit_o = hit_x & hit_y & hit_z;

endmodule

@@ rtl/aabb_trigger_overlap_tracker.sv @@
// Write and remove complete in idle; the next transaction is taken the cycle after.
// Tick: tests every pair (one RAM read of two boxes per cycle), then walks the
// event positions in order (up to 2 * PAIR_COUNT), paced by the event scan and
// by output back-pressure; no results for write and remove.
// Reset clears the valid bits, the recorded overlaps and the output valid, and
// returns to idle with the input ready; box data in the RAM is undefined until written.
// ----------------------------------------------------------------------------
// aabb_trigger_overlap_tracker
// Tracks overlaps between trigger boxes and reports enter and exit events.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module aabb_trigger_overlap_tracker
  import aabb_tot_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // op[1:0], slot[4:2], active[5], owner[13:6], min_x[37:14], min_y[61:38],
  // min_z[85:62], max_x[109:86], max_y[133:110], max_z[157:134], zero pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // first_slot[2:0], second_slot[5:3], zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  // kind[0]
  output logic                  m_axis_tuser_o,
  output logic                  m_axis_tlast_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  state_e                  state_q, state_d;
  logic [MAX_TRIGGERS-1:0] valid_q, valid_d;
  logic [PAIR_COUNT-1:0]   prior_q, prior_d;
  logic [PAIR_COUNT-1:0]   now_q, now_d;
  logic [EV_COUNT-1:0]     mask_q, mask_d;
  logic [IDX_W-1:0]        i_q, i_d, j_q, j_d;
  logic [PAIR_W-1:0]       p_q, p_d, p_rd_q, p_rd_d;
  logic                    pend_q, pend_d;
  logic                    pv_q, pv_d;
  logic [EV_W-1:0]         k_q, k_d;
  logic                    out_valid_q, out_valid_d;
  logic                    out_kind_q, out_kind_d;
  logic                    out_last_q, out_last_d;
  logic [SLOT_W-1:0]       out_first_q, out_first_d, out_second_q, out_second_d;

  logic                    in_fire;
  op_e                     in_op;
  logic [SLOT_W-1:0]       in_slot;
  logic                    in_active;
  logic                    slot_ok;
  logic                    ram_we;
  logic [BOX_W-1:0]        rd_a, rd_b;
  box_t                    box_a, box_b;
  logic                    hit;
  logic                    out_free;
  logic                    ev_kind;
  logic [PAIR_W-1:0]       ev_pair;
  logic [EV_COUNT-1:0]     mask_left;

  // Input transaction fields.
  assign in_fire   = s_axis_tvalid_i & s_axis_tready_o;
  assign in_op     = op_e'(s_axis_tdata_i[1:0]);
  assign in_slot   = s_axis_tdata_i[4:2];
  assign in_active = s_axis_tdata_i[5];
  assign slot_ok   = 32'(in_slot) < MAX_TRIGGERS;
  assign ram_we    = in_fire && (in_op == OP_WRITE) && slot_ok;

  // The table is only written in idle and only read during a tick, so the
  // stalled input port keeps accesses to one entry from overlapping.
  aabb_tot_ram #(
    .Width (BOX_W),
    .Depth (MAX_TRIGGERS)
  ) u_box_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (in_slot[IDX_W-1:0]),
    .wdata_i   (s_axis_tdata_i[BOX_W+5:6]),
    .raddr_a_i (i_q),
    .raddr_b_i (j_q),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  assign box_a = box_t'(rd_a);
  assign box_b = box_t'(rd_b);

  aabb_tot_hit u_hit (
    .box_a_i (box_a),
    .box_b_i (box_b),
    .hit_o   (hit)
  );

  // Event position decode for the scan.
  assign out_free  = !out_valid_q || m_axis_tready_i;
  assign ev_kind   = 32'(k_q) >= PAIR_COUNT;
  assign ev_pair   = ev_kind ? PAIR_W'(32'(k_q) - PAIR_COUNT) : PAIR_W'(k_q);
  assign mask_left = mask_q & ~(EV_COUNT'(1) << k_q);

  // Next-state logic.
  always_comb begin
    state_d      = state_q;
    valid_d      = valid_q;
    prior_d      = prior_q;
    now_d        = now_q;
    mask_d       = mask_q;
    i_d          = i_q;
    j_d          = j_q;
    p_d          = p_q;
    p_rd_d       = p_rd_q;
    pend_d       = 1'b0;
    pv_d         = pv_q;
    k_d          = k_q;
    out_valid_d  = out_valid_q & ~m_axis_tready_i;
    out_kind_d   = out_kind_q;
    out_last_d   = out_last_q;
    out_first_d  = out_first_q;
    out_second_d = out_second_q;

    // Capture the pair result that arrives from the RAM this cycle.
    if (pend_q) begin
      now_d[p_rd_q] = pv_q && (box_a.owner != box_b.owner) && hit;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_op)
            OP_WRITE: begin
              if (slot_ok) begin
                valid_d[in_slot[IDX_W-1:0]] = in_active;
              end
            end
            OP_REMOVE: begin
              if (slot_ok) begin
                valid_d[in_slot[IDX_W-1:0]] = 1'b0;
                prior_d = prior_q & ~slot_pairs(in_slot[IDX_W-1:0]);
              end
            end
            OP_TICK: begin
              state_d = ST_EVAL;
              now_d   = '0;
              i_d     = '0;
              j_d     = IDX_W'(1);
              p_d     = '0;
            end
            default: ;
          endcase
        end
      end

      // Present one pair per cycle to the RAM.
      ST_EVAL: begin
        pend_d = 1'b1;
        p_rd_d = p_q;
        pv_d   = valid_q[i_q] & valid_q[j_q];
        if (32'(p_q) == PAIR_COUNT - 1) begin
          state_d = ST_DRAIN;
        end else begin
          p_d = p_q + PAIR_W'(1);
          if (32'(j_q) == MAX_TRIGGERS - 1) begin
            i_d = i_q + IDX_W'(1);
            j_d = i_q + IDX_W'(2);
          end else begin
            j_d = j_q + IDX_W'(1);
          end
        end
      end

      // Last pair lands; build the event mask, enters before exits.
      ST_DRAIN: begin
        mask_d  = {prior_q & ~now_d & valid_pairs(valid_q), now_d & ~prior_q};
        prior_d = now_d;
        k_d     = '0;
        state_d = ST_EMIT;
      end

      // Walk the event positions in order.
      ST_EMIT: begin
        if (mask_q == '0) begin
          state_d = ST_IDLE;
        end else if (mask_q[k_q]) begin
          if (out_free) begin
            out_valid_d  = 1'b1;
            out_kind_d   = ev_kind ? KIND_EXIT : KIND_ENTER;
            out_first_d  = PAIR_FIRST[ev_pair];
            out_second_d = PAIR_SECOND[ev_pair];
            out_last_d   = (mask_left == '0);
            mask_d       = mask_left;
            k_d          = k_q + EV_W'(1);
            if (mask_left == '0) begin
              state_d = ST_IDLE;
            end
          end
        end else begin
          k_d = k_q + EV_W'(1);
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      prior_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      prior_q     <= prior_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload and scan registers.
  always_ff @(posedge clk_i) begin
    now_q        <= now_d;
    mask_q       <= mask_d;
    i_q          <= i_d;
    j_q          <= j_d;
    p_q          <= p_d;
    p_rd_q       <= p_rd_d;
    pv_q         <= pv_d;
    k_q          <= k_d;
    out_kind_q   <= out_kind_d;
    out_last_q   <= out_last_d;
    out_first_q  <= out_first_d;
    out_second_q <= out_second_d;
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OUT_DATA_W - 2 * SLOT_W){1'b0}}, out_second_q, out_first_q};
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;

  // The recorded overlap set stays put while pairs are being tested.
  `TRK_ASSERT(a_prior_stable_eval, (state_q == ST_EVAL) |=> $stable(prior_q), "prior changed in eval")
  // A removed slot leaves no recorded overlap behind.
  `TRK_ASSERT(a_remove_clears, (in_fire && (in_op == OP_REMOVE) && slot_ok) |=> ((prior_q & slot_pairs($past(in_slot[IDX_W-1:0]))) == '0), "remove left overlaps")
  // Every reported pair names the lower slot first.
  `TRK_ASSERT_NEVER(a_pair_order, m_axis_tvalid_o && (out_first_q >= out_second_q), "pair out of order")

endmodule
